[hw/rtl/vdist_pkg.sv]
`timescale 1ns / 1ps
package vdist_pkg;

  localparam int ACCW = 50;
  localparam int NRMW = 48;
  localparam int OUTW = 48;
  localparam int QW   = 17;

  localparam logic signed [ACCW-1:0] ACC_SMAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [ACCW-1:0] ACC_SMIN = -50'sh0_8000_0000_0000;
  localparam logic signed [ACCW-1:0] ACC_UMAX = 50'sh0_FFFF_FFFF_FFFF;
  localparam logic [NRMW-1:0]        NRM_MAX  = '1;
  localparam logic [QW-1:0]          ONE_Q16  = 17'd65536;

  typedef struct packed {
    logic signed [15:0] x_elem;
    logic signed [15:0] y_elem;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [OUTW-1:0] distance;
    logic            zero_norm;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_MUL_P, ST_MUL_R, ST_SEARCH, ST_SQ, ST_MUL_U, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MSEL_P, MSEL_R, MSEL_U
  } mul_sel_t;

  typedef enum logic [1:0] {
    EMIT_NONE, EMIT_L2, EMIT_ZERO, EMIT_COS
  } emit_t;

  typedef struct packed {
    logic     acc_en;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     cap_p;
    logic     cap_r;
    logic     srch_init;
    logic     sq_load;
    logic     update;
    emit_t    emit;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic zero_norm;
    logic lo_lt_hi;
    logic mul_done;
    logic out_hold;
  } status_t;

endpackage

[hw/rtl/vdist_mul.sv]
`timescale 1ns / 1ps
module vdist_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [95:0]  a,
  input  logic [63:0]  b,
  output logic         busy,
  output logic         done,
  output logic [159:0] prod
);

  logic [2:0][31:0] a_q;
  logic [1:0][31:0] b_q;
  logic [2:0]       cnt;
  logic [1:0]       ia;
  logic             ib;
  logic [63:0]      part;
  logic [6:0]       sh;

  assign ia   = cnt[2:1];
  assign ib   = cnt[0];
  assign part = 64'(a_q[ia]) * 64'(b_q[ib]);
  assign sh   = {3'(ia) + 3'(ib), 4'd0} << 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        a_q  <= a;
        b_q  <= b;
        prod <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= prod + (160'(part) << sh);
        cnt  <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");
  a_busy_ends: assert property (@(posedge clk) disable iff (rst)
    busy |=> (busy || done))
    else $error("busy dropped without done");

endmodule

[hw/rtl/vdist_ctrl.sv]
`timescale 1ns / 1ps
module vdist_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  input  vdist_pkg::status_t sts,
  output vdist_pkg::cmd_t    cmd
);
  import vdist_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MSEL_P;
    cmd.emit    = EMIT_NONE;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.acc_en = in_valid;
        if (in_valid && in_last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.out_hold) begin
          if (!sts.mode) begin
            cmd.emit   = EMIT_L2;
            state_next = ST_IDLE;
          end else if (sts.zero_norm) begin
            cmd.emit   = EMIT_ZERO;
            state_next = ST_IDLE;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_P;
            state_next    = ST_MUL_P;
          end
        end
      end
      ST_MUL_P: begin
        if (sts.mul_done) begin
          cmd.cap_p     = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_R;
          state_next    = ST_MUL_R;
        end
      end
      ST_MUL_R: begin
        if (sts.mul_done) begin
          cmd.cap_r     = 1'b1;
          cmd.srch_init = 1'b1;
          state_next    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.lo_lt_hi) begin
          cmd.sq_load = 1'b1;
          state_next  = ST_SQ;
        end else begin
          state_next  = ST_EMIT;
        end
      end
      ST_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_U;
        state_next    = ST_MUL_U;
      end
      ST_MUL_U: begin
        if (sts.mul_done) begin
          cmd.update = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_EMIT: begin
        if (!sts.out_hold) begin
          cmd.emit   = EMIT_COS;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/vdist_dp.sv]
`timescale 1ns / 1ps
module vdist_dp #(
  parameter int ELEM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vdist_pkg::in_word_t  in_word,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  vdist_pkg::cmd_t      cmd,
  output vdist_pkg::status_t   sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vdist_pkg::out_word_t out_word
);
  import vdist_pkg::*;

  localparam int EB = ELEM_BITS;

  logic                   mode;
  logic signed [ACCW-1:0] acc, acc_next;
  logic [NRMW-1:0]        nx, nx_next, ny, ny_next;
  logic [95:0]            p;
  logic [127:0]           rhs;
  logic [QW-1:0]          lo, hi, kq;
  logic [33:0]            odd2;

  logic signed [EB-1:0]     xe, ye;
  logic signed [EB:0]       d;
  logic signed [2*EB+1:0]   dsq;
  logic signed [2*EB-1:0]   xy, xx, yy;
  logic signed [ACCW-1:0]   s_l2, s_cos;
  logic [NRMW:0]            snx, sny;

  assign xe   = in_word.x_elem[EB-1:0];
  assign ye   = in_word.y_elem[EB-1:0];
  assign d    = {xe[EB-1], xe} - {ye[EB-1], ye};
  assign dsq  = d * d;
  assign xy   = xe * ye;
  assign xx   = xe * xe;
  assign yy   = ye * ye;
  assign s_l2  = acc + ACCW'(dsq);
  assign s_cos = acc + ACCW'(xy);
  assign snx  = {1'b0, nx} + (NRMW+1)'(unsigned'(xx));
  assign sny  = {1'b0, ny} + (NRMW+1)'(unsigned'(yy));

  always_comb begin
    acc_next = acc;
    nx_next  = nx;
    ny_next  = ny;
    if (!mode) begin
      acc_next = (!acc[ACCW-1] && s_l2 > ACC_UMAX) ? ACC_UMAX : s_l2;
    end else begin
      if (s_cos > ACC_SMAX)      acc_next = ACC_SMAX;
      else if (s_cos < ACC_SMIN) acc_next = ACC_SMIN;
      else                       acc_next = s_cos;
      nx_next = snx[NRMW] ? NRM_MAX : snx[NRMW-1:0];
      ny_next = sny[NRMW] ? NRM_MAX : sny[NRMW-1:0];
    end
  end

  // clamp dot and form 2 * 65536 * |dot|, kept to 64 bits
  logic signed [ACCW-1:0] dcl;
  logic [ACCW-1:0]        mag;
  logic [63:0]            s64;
  logic [QW:0]            ksum;
  logic [QW-1:0]          k, odd;
  logic [95:0]            mul_a;
  logic [63:0]            mul_b;
  logic                   mul_busy, mul_done;
  logic [159:0]           mul_prod;

  assign dcl  = (acc > ACC_SMAX) ? ACC_SMAX : acc;
  assign mag  = dcl[ACCW-1] ? unsigned'(-dcl) : unsigned'(dcl);
  assign s64  = {mag[46:0], 17'd0};
  assign ksum = ({1'b0, lo} + {1'b0, hi} + (QW+1)'(1)) >> 1;
  assign k    = ksum[QW-1:0];
  assign odd  = (k << 1) - QW'(1);

  always_comb begin
    case (cmd.mul_sel)
      MSEL_P:  begin mul_a = 96'(nx);  mul_b = 64'(ny);   end
      MSEL_R:  begin mul_a = 96'(s64); mul_b = s64;       end
      MSEL_U:  begin mul_a = p;        mul_b = 64'(odd2); end
      default: begin mul_a = '0;       mul_b = '0;        end
    endcase
  end

  vdist_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  logic clear;
  assign clear = (cmd.emit != EMIT_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      acc  <= '0;
      nx   <= '0;
      ny   <= '0;
    end else begin
      if (cfg_we) mode <= cfg_data;
      if (clear) begin
        acc <= '0;
        nx  <= '0;
        ny  <= '0;
      end else if (cmd.acc_en) begin
        acc <= acc_next;
        nx  <= nx_next;
        ny  <= ny_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_p) p   <= mul_prod[95:0];
    if (cmd.cap_r) rhs <= mul_prod[127:0];
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= ONE_Q16;
    end
    if (cmd.sq_load) begin
      odd2 <= 34'(odd) * 34'(odd);
      kq   <= k;
    end
    if (cmd.update) begin
      if (mul_prod <= 160'(rhs)) lo <= kq;
      else                       hi <= kq - QW'(1);
    end
  end

  // result word: hold while stalled, reload as it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (clear)          out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_L2: begin
        out_word.distance  <= acc[ACCW-1] ? '0 : acc[OUTW-1:0];
        out_word.zero_norm <= 1'b0;
      end
      EMIT_ZERO: begin
        out_word.distance  <= '0;
        out_word.zero_norm <= 1'b1;
      end
      EMIT_COS: begin
        out_word.distance  <= acc[ACCW-1] ? OUTW'(ONE_Q16) + OUTW'(lo)
                                          : OUTW'(ONE_Q16) - OUTW'(lo);
        out_word.zero_norm <= 1'b0;
      end
      default: ;
    endcase
  end

  assign sts.mode      = mode;
  assign sts.zero_norm = (nx == '0) || (ny == '0);
  assign sts.lo_lt_hi  = (lo < hi);
  assign sts.mul_done  = mul_done && !mul_busy;
  assign sts.out_hold  = out_valid && out_stall;

endmodule

[hw/rtl/vector_distance_l2_cosine_top.sv]
`timescale 1ns / 1ps
// Streaming distance unit: one element pair word per cycle, while the unit
// is idle and not stalling the input, is summed as it arrives (squared
// difference in euclidean mode, dot product and both norms in cosine mode),
// and the pair marked last closes the vector. A last word in euclidean mode,
// or in cosine mode with a zero norm, is summed into the accumulators; the
// check state then registers the result into the output word once the
// previous result is no longer held. In cosine mode the distance
// 1 - dot/sqrt(nx*ny) comes from a binary search over 17 result bits, each
// probe one 96x34 product built from 32x32 partial products in a shared
// six-step multiplier; a probe passes the pick, square and product states.
// The back part holds the input through the check, the two setup products,
// the probes, the final compare and the emit. The result word sits in an
// output register, so the next vector may start while it waits to be taken.
module vector_distance_l2_cosine_top #(
  parameter int ELEM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vdist_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vdist_pkg::out_word_t out_word,
  input  logic                 cfg_we,
  input  logic                 cfg_data
);
  import vdist_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequencing: accept, finish, search
  vdist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_word.last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // accumulators, search registers and the result word
  vdist_dp #(.ELEM_BITS(ELEM_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
